[rtl/lkv_pkg.sv]
// Shared types and constants for the LRU key-value cache.
package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic signed [KEY_W-1:0] lookup_key;
        logic signed [VAL_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } rsp_t;

endpackage

[rtl/lkv_req_if.sv]
// Request channel: get or put with key and value.
interface lkv_req_if;
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic signed [31:0]    lookup_key;
    logic signed [31:0]    write_value;

    modport source (output valid, cmd, lookup_key, write_value, input ready);
    modport sink   (input valid, cmd, lookup_key, write_value, output ready);
endinterface

[rtl/lkv_rsp_if.sv]
// Response channel: hit, read value and eviction report.
interface lkv_rsp_if;
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic signed [31:0]    read_value;
    logic                  evicted;
    logic signed [31:0]    evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

[rtl/lkv_cfg_if.sv]
// Configuration write channel carrying the capacity limit.
interface lkv_cfg_if;
    logic          valid;
    logic          ready;
    logic [4:0]    capacity_limit;

    modport source (output valid, capacity_limit, input ready);
    modport sink   (input valid, capacity_limit, output ready);
endinterface

[rtl/lru_key_value_cache_top.sv]
// Top level of the LRU key-value cache.
//
//  channel  dir  payload                                     handshake
//  req      in   cmd, lookup_key, write_value                valid/ready
//  rsp      out  hit, read_value, evicted, evicted_key       valid/ready
//  cfg      in   capacity_limit                              valid/ready (always ready)
//
// One request per cycle while the response is not stalled.
// Lookup, replacement choice and rank update for one request run combinationally
// between the request register and the response register.
// Reset clears all entries and sets the capacity to 16; no clearing pass is needed.
// A stalled response holds the request register, which then holds the request port.
module lru_key_value_cache_top (
    input  logic       clk,
    input  logic       rst_n,
    lkv_req_if.sink    req,
    lkv_rsp_if.source  rsp,
    lkv_cfg_if.sink    cfg
);

    logic           stage_valid;
    lkv_pkg::req_t  stage_data;
    lkv_pkg::rsp_t  result;
    logic           advance;
    logic           fire;

    assign fire = stage_valid && advance;

    lkv_req_reg u_req_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .advance (advance),
        .valid   (stage_valid),
        .data    (stage_data)
    );

    lkv_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (fire),
        .req   (stage_data),
        .rsp   (result)
    );

    lkv_rsp_reg u_rsp_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stage_valid),
        .data     (result),
        .advance  (advance),
        .rsp      (rsp)
    );

endmodule

[rtl/lkv_req_reg.sv]
// Input register stage for requests.
module lkv_req_reg (
    input  logic              clk,
    input  logic              rst_n,
    lkv_req_if.sink           req,
    input  logic              advance,
    output logic              valid,
    output lkv_pkg::req_t     data
);

    logic           valid_reg;
    logic           valid_next;
    lkv_pkg::req_t  data_reg;
    logic           take;

    assign req.ready = !valid_reg || advance;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg.cmd         <= lkv_pkg::cmd_t'(req.cmd);
            data_reg.lookup_key  <= req.lookup_key;
            data_reg.write_value <= req.write_value;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

[rtl/lkv_store.sv]
// Entry storage, parallel key match and recency rank update.
module lkv_store (
    input  logic              clk,
    input  logic              rst_n,
    lkv_cfg_if.sink           cfg,
    input  logic              fire,
    input  lkv_pkg::req_t     req,
    output lkv_pkg::rsp_t     rsp
);

    localparam int N  = lkv_pkg::ENTRIES;
    localparam int RW = lkv_pkg::RANK_W;
    localparam int OW = lkv_pkg::OCC_W;

    logic [N-1:0]                     valid_reg, valid_next;
    logic [N-1:0][RW-1:0]             rank_reg, rank_next;
    logic [N-1:0][lkv_pkg::KEY_W-1:0] key_reg, key_next;
    logic [N-1:0][lkv_pkg::VAL_W-1:0] value_reg, value_next;
    logic [OW-1:0]                    occ_reg, occ_next;
    logic [lkv_pkg::CAP_W-1:0]        cap_reg;

    logic [N-1:0]                match;
    logic [N-1:0]                drop;
    logic [N-1:0]                slot;
    logic                        slot_taken;
    logic                        hit;
    logic [lkv_pkg::VAL_W-1:0]   hit_value;
    logic [RW-1:0]               hit_rank;
    logic [lkv_pkg::KEY_W-1:0]   oldest_key;
    logic [OW-1:0]               eff_cap;
    logic [OW-1:0]               limit;
    logic [OW-1:0]               last_rank;
    logic                        overflow;
    logic                        is_put;

    assign cfg.ready = 1'b1;
    assign is_put    = (req.cmd == lkv_pkg::CMD_PUT);

    always_comb
    begin
        // capacity 0 acts as 1, anything above the entry count acts as full size
        if (cap_reg == '0)
        begin
            eff_cap = OW'(1);
        end
        else if (32'(cap_reg) > N)
        begin
            eff_cap = OW'(N);
        end
        else
        begin
            eff_cap = OW'(cap_reg);
        end
        limit     = eff_cap - OW'(1);
        last_rank = occ_reg - OW'(1);
        overflow  = occ_reg > limit;

        hit        = 1'b0;
        hit_value  = '0;
        hit_rank   = '0;
        oldest_key = '0;
        slot_taken = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == req.lookup_key);
            drop[i]  = valid_reg[i] && (OW'(rank_reg[i]) >= limit);
            hit       = hit | match[i];
            hit_value = hit_value | (match[i] ? value_reg[i] : '0);
            hit_rank  = hit_rank | (match[i] ? rank_reg[i] : '0);
            // ranks are distinct, so the oldest live entry holds rank occ-1
            if (valid_reg[i] && (OW'(rank_reg[i]) == last_rank))
            begin
                oldest_key = oldest_key | key_reg[i];
            end
            slot[i] = 1'b0;
            if (!slot_taken && (!valid_reg[i] || drop[i]))
            begin
                slot[i]    = 1'b1;
                slot_taken = 1'b1;
            end
        end

        valid_next = valid_reg;
        rank_next  = rank_reg;
        key_next   = key_reg;
        value_next = value_reg;
        occ_next   = occ_reg;

        if (fire)
        begin
            if (hit)
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (match[i])
                    begin
                        rank_next[i] = '0;
                        if (is_put)
                        begin
                            value_next[i] = req.write_value;
                        end
                    end
                    else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                    begin
                        rank_next[i] = rank_reg[i] + RW'(1);
                    end
                end
            end
            else if (is_put)
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (slot[i])
                    begin
                        valid_next[i] = 1'b1;
                        key_next[i]   = req.lookup_key;
                        value_next[i] = req.write_value;
                        rank_next[i]  = '0;
                    end
                    else if (drop[i])
                    begin
                        valid_next[i] = 1'b0;
                        rank_next[i]  = '0;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + RW'(1);
                    end
                end
                occ_next = (overflow ? limit : occ_reg) + OW'(1);
            end
        end

        rsp.hit = hit;
        if (is_put)
        begin
            rsp.read_value = '0;
        end
        else if (hit)
        begin
            rsp.read_value = hit_value;
        end
        else
        begin
            rsp.read_value = lkv_pkg::MISS_VALUE;
        end
        rsp.evicted     = is_put && !hit && overflow;
        rsp.evicted_key = rsp.evicted ? oldest_key : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rank_reg  <= '0;
            occ_reg   <= '0;
            cap_reg   <= lkv_pkg::CAP_RESET;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            occ_reg   <= occ_next;
            if (cfg.valid)
            begin
                cap_reg <= cfg.capacity_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

[rtl/lkv_rsp_reg.sv]
// Result register stage driving the response channel.
module lkv_rsp_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  lkv_pkg::rsp_t     data,
    output logic              advance,
    lkv_rsp_if.source         rsp
);

    logic           valid_reg;
    logic           valid_next;
    lkv_pkg::rsp_t  data_reg;
    logic           load;

    assign advance = !valid_reg || rsp.ready;
    assign load    = in_valid && advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.hit         = data_reg.hit;
    assign rsp.read_value  = data_reg.read_value;
    assign rsp.evicted     = data_reg.evicted;
    assign rsp.evicted_key = data_reg.evicted_key;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for the LRU key-value cache: shadow LRU model, directed and random requests.
module tb_top;
    import lkv_pkg::*;

    localparam int SEGMENTS      = 12;
    localparam int SEGMENT_ITEMS = 108;
    localparam int KEY_POOL      = 24;
    localparam int DRAIN_LIMIT   = 20000;

    // Shadow copy of the cache plus the queue of responses it predicts.
    class lru_checker;
        logic                slot_live [ENTRIES];
        logic [KEY_W-1:0]    slot_key  [ENTRIES];
        logic [VAL_W-1:0]    slot_val  [ENTRIES];
        logic [RANK_W-1:0]   slot_age  [ENTRIES];
        logic [CAP_W-1:0]    capacity;
        rsp_t                expected_rsp[$];
        int                  mismatches;

        function new();
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_live[i] = 1'b0;
                slot_key[i]  = '0;
                slot_val[i]  = '0;
                slot_age[i]  = '0;
            end
            capacity   = CAP_RESET;
            mismatches = 0;
        endfunction

        function void make_newest(int idx);
            logic [RANK_W-1:0] r;
            r = slot_age[idx];
            for (int i = 0; i < ENTRIES; i++)
                if (slot_live[i] && slot_age[i] < r)
                    slot_age[i] = slot_age[i] + RANK_W'(1);
            slot_age[idx] = '0;
        endfunction

        function void note_request(req_t r);
            rsp_t              exp;
            int                found;
            int                slot;
            int                eff;
            logic [RANK_W-1:0] oldest;
            exp    = '0;
            found  = -1;
            slot   = -1;
            oldest = '0;
            for (int i = 0; i < ENTRIES; i++)
                if (found < 0 && slot_live[i] && slot_key[i] == r.lookup_key)
                    found = i;
            if (r.cmd == CMD_GET)
            begin
                if (found >= 0)
                begin
                    exp.hit        = 1'b1;
                    exp.read_value = slot_val[found];
                    make_newest(found);
                end
                else
                    exp.read_value = MISS_VALUE;
            end
            else if (found >= 0)
            begin
                exp.hit         = 1'b1;
                slot_val[found] = r.write_value;
                make_newest(found);
            end
            else
            begin
                eff = int'(capacity);
                if (eff < 1)
                    eff = 1;
                if (eff > ENTRIES)
                    eff = ENTRIES;
                // drop everything ranked at or past capacity-1, report the oldest
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_live[i] && int'(slot_age[i]) >= eff - 1)
                    begin
                        if (!exp.evicted || slot_age[i] > oldest)
                        begin
                            oldest          = slot_age[i];
                            exp.evicted_key = slot_key[i];
                        end
                        exp.evicted  = 1'b1;
                        slot_live[i] = 1'b0;
                        slot_age[i]  = '0;
                    end
                end
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_live[i])
                        slot_age[i] = slot_age[i] + RANK_W'(1);
                    else if (slot < 0)
                        slot = i;
                end
                if (slot >= 0)
                begin
                    slot_live[slot] = 1'b1;
                    slot_key[slot]  = r.lookup_key;
                    slot_val[slot]  = r.write_value;
                    slot_age[slot]  = '0;
                end
            end
            expected_rsp.push_back(exp);
        endfunction

        function void flag(string field, logic [31:0] exp_v, logic [31:0] act_v);
            mismatches++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
        endfunction

        function void check_response(rsp_t got);
            rsp_t exp;
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected response, expected none actual %h", $time, got);
                return;
            end
            exp = expected_rsp.pop_front();
            if (got.hit !== exp.hit)
                flag("hit", 32'(exp.hit), 32'(got.hit));
            if (got.read_value !== exp.read_value)
                flag("read_value", exp.read_value, got.read_value);
            if (got.evicted !== exp.evicted)
                flag("evicted", 32'(exp.evicted), 32'(got.evicted));
            if (got.evicted_key !== exp.evicted_key)
                flag("evicted_key", exp.evicted_key, got.evicted_key);
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    int               src_idle_pct;
    int               sink_idle_pct;
    lru_checker       sb;
    logic [KEY_W-1:0] key_pool [KEY_POOL];
    logic [CAP_W-1:0] cap_plan [SEGMENTS] = '{5'd1, 5'd4, 5'd16, 5'd0, 5'd31, 5'd2,
                                              5'd8, 5'd17, 5'd3, 5'd15, 5'd12, 5'd5};

    lkv_req_if req_ch();
    lkv_rsp_if rsp_ch();
    lkv_cfg_if cfg_ch();

    lru_key_value_cache_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);

    // responses first, then the request of the same edge
    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response({rsp_ch.hit, rsp_ch.read_value, rsp_ch.evicted,
                               rsp_ch.evicted_key});
        if (req_ch.valid && req_ch.ready)
            sb.note_request({cmd_t'(req_ch.cmd), req_ch.lookup_key, req_ch.write_value});
        if (cfg_ch.valid && cfg_ch.ready)
            sb.capacity = cfg_ch.capacity_limit;
    end

    task automatic send_request(input cmd_t op, input logic [31:0] k, input logic [31:0] v);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= op;
        req_ch.lookup_key  <= k;
        req_ch.write_value <= v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        // a request taken on this edge may not be logged by the monitor yet
        @(posedge clk);
        for (int n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        wait_drained();
        cfg_ch.valid          <= 1'b1;
        cfg_ch.capacity_limit <= c;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int   eff;
        int   span;
        cmd_t op;
        logic [31:0] k;
        sb                    = new();
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.cmd            = CMD_GET;
        req_ch.lookup_key     = '0;
        req_ch.write_value    = '0;
        rsp_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.capacity_limit = '0;
        src_idle_pct          = 33;
        sink_idle_pct         = 79;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < KEY_POOL; i++)
            key_pool[i] = $urandom;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty cache, extreme keys and values, hit returning all ones, update
        send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
        send_request(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
        send_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_PUT, 32'hffff_ffff, 32'hffff_ffff);
        send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(CMD_GET, 32'hffff_ffff, 32'h5555_5555);
        send_request(CMD_PUT, 32'h0000_0000, 32'h1234_5678);
        send_request(CMD_GET, 32'h0000_0005, 32'hffff_ffff);
        for (int i = 0; i < 12; i++)
            send_request(CMD_PUT, 32'd100 + i, $urandom);
        // full at 16: next new key pushes out the least recent
        send_request(CMD_PUT, 32'd200, 32'hdead_beef);
        send_request(CMD_GET, 32'h7fff_ffff, 32'h0000_0000);

        // capacity dropped under occupancy: gets and updates keep everything
        write_capacity(5'd2);
        send_request(CMD_GET, 32'd100, 32'h0000_0000);
        send_request(CMD_PUT, 32'd101, 32'hcafe_f00d);
        send_request(CMD_PUT, 32'd300, 32'h0000_0001);
        // zero behaves as one
        write_capacity(5'd0);
        send_request(CMD_PUT, 32'd301, 32'h0000_0002);
        send_request(CMD_PUT, 32'd302, 32'h0000_0003);
        send_request(CMD_GET, 32'd301, 32'h0000_0000);
        // above the entry count behaves as sixteen
        write_capacity(5'd31);
        send_request(CMD_PUT, 32'd400, 32'h0000_0004);
        send_request(CMD_PUT, 32'd401, 32'h0000_0005);

        for (int s = 0; s < SEGMENTS; s++)
        begin
            write_capacity(cap_plan[s]);
            if (s < 4)
            begin
                src_idle_pct  = 33;
                sink_idle_pct = 79;
            end
            else if (s < 8)
            begin
                src_idle_pct  = 79;
                sink_idle_pct = 33;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            eff = int'(cap_plan[s]);
            if (eff < 1)
                eff = 1;
            if (eff > ENTRIES)
                eff = ENTRIES;
            // a pool a little larger than capacity keeps both hits and evictions coming
            span = eff + $urandom_range(1, 6);
            for (int i = 0; i < SEGMENT_ITEMS; i++)
            begin
                op = $urandom_range(1) ? CMD_PUT : CMD_GET;
                k  = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(span - 1)];
                send_request(op, k, $urandom);
            end
        end

        wait_drained();
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d responses missing, expected %0d actual 0", $time,
                     sb.pending(), sb.pending());
            sb.mismatches += sb.pending();
        end
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
